// ===== hdl/acss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC channel scan sequencer package
// Shared sizes, codes and record types of the scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int DATA_DEPTH    = 32;
    localparam int DMA_BLOCK_MAX = 32;

    // Channel index width, and a scan pointer that can also hold NUM_CHANNELS.
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W = CH_W + 1;

    localparam logic [7:0] BUSY_LIMIT_RESET = 8'd3;

    typedef enum logic [2:0] {
        MD_TRIGGER    = 3'd0,
        MD_CONV_DONE  = 3'd1,
        MD_ERROR      = 3'd2,
        MD_REGISTER   = 3'd3,
        MD_UNREGISTER = 3'd4,
        MD_PRIO_START = 3'd5,
        MD_PRIO_END   = 3'd6,
        MD_QUERY      = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_BUSY = 2'd1,
        CS_DONE = 2'd2
    } t_chan_st;

    typedef enum logic [1:0] {
        CY_IDLE    = 2'd0,
        CY_WORK    = 2'd1,
        CY_SUSPEND = 2'd2
    } t_cycle;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_PRIO_BUSY = 2'd2
    } t_rsp_status;

    typedef struct packed {
        logic       registered;
        logic [7:0] samples;
        t_chan_st   status;
        logic [7:0] stuck;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        registered: 1'b0,
        samples:    8'd0,
        status:     CS_IDLE,
        stuck:      8'd0
    };

    // One access to the channel table: read and write share the address.
    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] addr;
        t_entry          wdata;
    } t_tab_req;

    typedef struct packed {
        t_rsp_status status;
        logic        go_valid;
        logic [4:0]  go_channel;
        logic [7:0]  go_count;
        logic        stop;
        logic        pgo;
        logic        data_ready;
        t_cycle      cycle_mode;
        logic        prio_active;
    } t_rsp;

endpackage
`default_nettype wire

// ===== hdl/acss_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared increment and compare unit
// Adds an optional one to an 8-bit operand and compares the sum against a
// second operand. Serves the stuck counter bump and the query length check.
// ----------------------------------------------------------------------------
module acss_alu (
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    input  wire logic       i_add_one,
    output logic      [7:0] o_sum,
    output logic            o_ge
);
    import acss_pkg::*;

    assign o_sum = i_a + {7'd0, i_add_one};
    assign o_ge  = (o_sum >= i_b);

endmodule
`default_nettype wire

// ===== hdl/acss_chan_tab.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel table
// Per-channel registration, sample count, state and stuck counter, with one
// shared address for a combinational read and a clocked write.
// ----------------------------------------------------------------------------
module acss_chan_tab (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acss_pkg::t_tab_req i_req,
    output acss_pkg::t_entry       o_rdata
);
    import acss_pkg::*;

    t_entry r_tab [NUM_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_tab[i] <= ENTRY_RESET;
            end
        end else if (i_req.we) begin
            r_tab[i_req.addr] <= i_req.wdata;
        end
    end

    assign o_rdata = r_tab[i_req.addr];

endmodule
`default_nettype wire

// ===== hdl/acss_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan sequencer control
// Decodes one request, updates the cycle state and walks the channel table
// one entry per cycle when a scan is needed, then hands over the result.
// ----------------------------------------------------------------------------
module acss_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire logic [2:0]        i_mode,
    input  wire logic [7:0]        i_channel,
    input  wire logic [7:0]        i_count,
    input  wire logic [7:0]        i_busy_limit,
    output acss_pkg::t_tab_req     o_tab,
    input  wire acss_pkg::t_entry  i_tab_rdata,
    output acss_pkg::t_rsp         o_rsp,
    output logic                   o_rsp_load,
    input  wire logic              i_rsp_free
);
    import acss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state            r_state,      n_state;
    t_mode             r_mode,       n_mode;
    logic [7:0]        r_ch,         n_ch;
    logic [7:0]        r_cnt,        n_cnt;
    logic [PTR_W-1:0]  r_ptr,        n_ptr;
    logic [CH_W-1:0]   r_scan_pos,   n_scan_pos;
    t_cycle            r_cycle_now,  n_cycle_now;
    t_cycle            r_cycle_bef,  n_cycle_bef;
    logic              r_prio_busy,  n_prio_busy;
    t_rsp_status       r_status,     n_status;
    logic              r_go_valid,   n_go_valid;
    logic [4:0]        r_go_ch,      n_go_ch;
    logic [7:0]        r_go_cnt,     n_go_cnt;
    logic              r_stop,       n_stop;
    logic              r_pgo,        n_pgo;
    logic              r_ready,      n_ready;

    logic [7:0]        alu_a;
    logic [7:0]        alu_b;
    logic              alu_add_one;
    logic [7:0]        alu_sum;
    logic              alu_ge;
    logic              ch_ok;
    logic              cnt_ok;
    logic [PTR_W-1:0]  pos_next;
    logic [7:0]        clip_cnt;

    acss_alu u_alu (
        .i_a       (alu_a),
        .i_b       (alu_b),
        .i_add_one (alu_add_one),
        .o_sum     (alu_sum),
        .o_ge      (alu_ge)
    );

    assign ch_ok    = (r_ch < 8'(NUM_CHANNELS));
    assign cnt_ok   = (r_cnt <= 8'(DATA_DEPTH));
    assign pos_next = {1'b0, r_scan_pos} + PTR_W'(1);
    assign clip_cnt = (i_tab_rdata.samples > 8'(DMA_BLOCK_MAX)) ? 8'(DMA_BLOCK_MAX)
                                                                : i_tab_rdata.samples;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ch        = r_ch;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_scan_pos  = r_scan_pos;
        n_cycle_now = r_cycle_now;
        n_cycle_bef = r_cycle_bef;
        n_prio_busy = r_prio_busy;
        n_status    = r_status;
        n_go_valid  = r_go_valid;
        n_go_ch     = r_go_ch;
        n_go_cnt    = r_go_cnt;
        n_stop      = r_stop;
        n_pgo       = r_pgo;
        n_ready     = r_ready;

        o_req_ready = 1'b0;
        o_rsp_load  = 1'b0;

        o_tab.we    = 1'b0;
        o_tab.wdata = i_tab_rdata;
        if (r_state == S_SCAN) begin
            o_tab.addr = r_ptr[CH_W-1:0];
        end else if (r_mode == MD_CONV_DONE) begin
            o_tab.addr = r_scan_pos;
        end else begin
            o_tab.addr = r_ch[CH_W-1:0];
        end

        // The shared unit bumps the stuck counter while scanning and checks
        // the requested length of a query otherwise.
        if (r_state == S_SCAN) begin
            alu_a       = i_tab_rdata.stuck;
            alu_b       = i_busy_limit;
            alu_add_one = 1'b1;
        end else begin
            alu_a       = i_tab_rdata.samples;
            alu_b       = r_cnt;
            alu_add_one = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_mode     = t_mode'(i_mode);
                    n_ch       = i_channel;
                    n_cnt      = i_count;
                    n_status   = ST_OK;
                    n_go_valid = 1'b0;
                    n_go_ch    = 5'd0;
                    n_go_cnt   = 8'd0;
                    n_stop     = 1'b0;
                    n_pgo      = 1'b0;
                    n_ready    = 1'b0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                unique case (r_mode)
                    MD_TRIGGER: begin
                        if (r_cycle_now == CY_IDLE && !r_prio_busy) begin
                            n_ptr   = {1'b0, r_scan_pos};
                            n_state = S_SCAN;
                        end
                    end
                    MD_CONV_DONE: begin
                        if (r_cycle_now == CY_WORK) begin
                            o_tab.we           = 1'b1;
                            o_tab.wdata.status = CS_DONE;
                            if (pos_next < PTR_W'(NUM_CHANNELS)) begin
                                n_scan_pos = pos_next[CH_W-1:0];
                                n_ptr      = pos_next;
                                n_state    = S_SCAN;
                            end else begin
                                n_scan_pos  = '0;
                                n_cycle_now = CY_IDLE;
                            end
                        end
                    end
                    MD_ERROR: begin
                        n_stop      = (r_cycle_now != CY_IDLE);
                        n_cycle_now = CY_IDLE;
                        n_prio_busy = 1'b0;
                    end
                    MD_REGISTER: begin
                        if (!ch_ok || !cnt_ok) begin
                            n_status = ST_BAD_PARAM;
                        end else begin
                            o_tab.we                = 1'b1;
                            o_tab.wdata.registered  = 1'b1;
                            o_tab.wdata.samples     = r_cnt;
                            o_tab.wdata.status      = CS_IDLE;
                        end
                    end
                    MD_UNREGISTER: begin
                        if (!ch_ok) begin
                            n_status = ST_BAD_PARAM;
                        end else begin
                            o_tab.we                = 1'b1;
                            o_tab.wdata.registered  = 1'b0;
                            o_tab.wdata.samples     = 8'd0;
                            o_tab.wdata.status      = CS_IDLE;
                        end
                    end
                    MD_PRIO_START: begin
                        if (!ch_ok || !cnt_ok) begin
                            n_status = ST_BAD_PARAM;
                        end else if (r_prio_busy) begin
                            n_status = ST_PRIO_BUSY;
                        end else begin
                            n_stop      = (r_cycle_now == CY_WORK);
                            n_cycle_bef = r_cycle_now;
                            n_cycle_now = CY_SUSPEND;
                            n_prio_busy = 1'b1;
                            n_pgo       = 1'b1;
                        end
                    end
                    MD_PRIO_END: begin
                        if (r_prio_busy) begin
                            n_prio_busy = 1'b0;
                            if (r_cycle_bef == CY_WORK) begin
                                n_cycle_now = CY_WORK;
                                n_ptr       = {1'b0, r_scan_pos};
                                n_state     = S_SCAN;
                            end else begin
                                n_cycle_now = CY_IDLE;
                            end
                        end
                    end
                    MD_QUERY: begin
                        if (!ch_ok || !alu_ge) begin
                            n_status = ST_BAD_PARAM;
                        end else begin
                            n_ready = (i_tab_rdata.status == CS_DONE);
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                priority if (r_ptr >= PTR_W'(NUM_CHANNELS)) begin
                    // Walked off the end without finding a free channel.
                    n_scan_pos  = '0;
                    n_cycle_now = CY_IDLE;
                    n_state     = S_RESP;
                end else if (!i_tab_rdata.registered) begin
                    n_ptr = r_ptr + PTR_W'(1);
                end else if (i_tab_rdata.status != CS_BUSY) begin
                    o_tab.we           = 1'b1;
                    o_tab.wdata.status = CS_BUSY;
                    n_go_valid         = 1'b1;
                    n_go_ch            = 5'(r_ptr);
                    n_go_cnt           = clip_cnt;
                    n_cycle_now        = CY_WORK;
                    n_scan_pos         = r_ptr[CH_W-1:0];
                    n_state            = S_RESP;
                end else begin
                    // A busy channel passed over: release it once it has been
                    // passed often enough.
                    o_tab.we          = 1'b1;
                    o_tab.wdata.stuck = alu_ge ? 8'd0 : alu_sum;
                    if (alu_ge) begin
                        o_tab.wdata.status = CS_IDLE;
                    end
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_RESP: begin
                if (i_rsp_free) begin
                    o_rsp_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rsp.status      = r_status;
        o_rsp.go_valid    = r_go_valid;
        o_rsp.go_channel  = r_go_ch;
        o_rsp.go_count    = r_go_cnt;
        o_rsp.stop        = r_stop;
        o_rsp.pgo         = r_pgo;
        o_rsp.data_ready  = r_ready;
        o_rsp.cycle_mode  = r_cycle_now;
        o_rsp.prio_active = r_prio_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_pos  <= '0;
            r_cycle_now <= CY_IDLE;
            r_cycle_bef <= CY_IDLE;
            r_prio_busy <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_pos  <= n_scan_pos;
            r_cycle_now <= n_cycle_now;
            r_cycle_bef <= n_cycle_bef;
            r_prio_busy <= n_prio_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_ch       <= n_ch;
        r_cnt      <= n_cnt;
        r_ptr      <= n_ptr;
        r_status   <= n_status;
        r_go_valid <= n_go_valid;
        r_go_ch    <= n_go_ch;
        r_go_cnt   <= n_go_cnt;
        r_stop     <= n_stop;
        r_pgo      <= n_pgo;
        r_ready    <= n_ready;
    end

`ifndef SYNTHESIS
    // The cycle is suspended exactly while a priority request holds the ADC.
    a_prio_suspend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cycle_now == CY_SUSPEND) == r_prio_busy)
        else $error("cycle suspend and priority flag disagree");

    // A start handed out always leaves the cycle working.
    a_start_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_load && r_go_valid) |-> (r_cycle_now == CY_WORK))
        else $error("start issued while the cycle is not working");

    // The scan pointer never runs past the end marker.
    a_ptr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= PTR_W'(NUM_CHANNELS)))
        else $error("scan pointer out of range");

    // A scan step that issues a start ends the walk on the next cycle.
    a_scan_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_go_valid) |=> (r_state == S_RESP))
        else $error("scan continued after a start");
`endif

endmodule
`default_nettype wire

// ===== hdl/adc_channel_scan_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Shares one ADC between registered channels and priority requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result for
// each. A request that does not scan (register, unregister, error, priority
// start, query, and triggers or completions that are ignored) passes from
// acceptance through the execute state and the response state to a loaded
// result. A request that scans walks the channel table through its single
// shared port, one channel per cycle, from the current scan position upward,
// between the execute state and the response state, and stops at the first
// free channel that it starts or when the walk runs off the end of the table.
// The result sits in an output register; the next request can be accepted
// while it waits to be taken. A result that finds that register still full
// waits inside the sequencer, which holds off the next request until the
// register is free. busy_limit may be written whenever no request is in
// flight.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_channel,
    input  wire logic [7:0] i_count,
    output logic            o_rsp_valid,
    input  wire logic       i_rsp_ready,
    output logic      [1:0] o_status,
    output logic            o_start_valid,
    output logic      [4:0] o_start_channel,
    output logic      [7:0] o_start_count,
    output logic            o_stop_request,
    output logic            o_prio_go,
    output logic            o_data_ready,
    output logic      [1:0] o_cycle_mode,
    output logic            o_prio_active,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);
    import acss_pkg::*;

    logic [7:0] r_busy_limit;
    t_rsp       r_out;
    logic       r_out_valid;
    t_tab_req   tab_req;
    t_entry     tab_rdata;
    t_rsp       seq_rsp;
    logic       rsp_load;
    logic       rsp_free;

    assign rsp_free = !r_out_valid || i_rsp_ready;

    acss_chan_tab u_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tab_req),
        .o_rdata (tab_rdata)
    );

    acss_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_mode       (i_mode),
        .i_channel    (i_channel),
        .i_count      (i_count),
        .i_busy_limit (r_busy_limit),
        .o_tab        (tab_req),
        .i_tab_rdata  (tab_rdata),
        .o_rsp        (seq_rsp),
        .o_rsp_load   (rsp_load),
        .i_rsp_free   (rsp_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_limit <= BUSY_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_busy_limit <= i_cfg_wdata;
            end
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_out <= seq_rsp;
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_start_valid   = r_out.go_valid;
    assign o_start_channel = r_out.go_channel;
    assign o_start_count   = r_out.go_count;
    assign o_stop_request  = r_out.stop;
    assign o_prio_go       = r_out.pgo;
    assign o_data_ready    = r_out.data_ready;
    assign o_cycle_mode    = r_out.cycle_mode;
    assign o_prio_active   = r_out.prio_active;

endmodule
`default_nettype wire

// ===== sim/adc_channel_scan_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC channel scan sequencer testbench
// Sends scan, completion, error, registration, priority and query requests
// through the valid/ready channels, with bursty sending and a stalling
// receiver. A shadow of the sequencer state works out each response that is
// not typed in, and every response is compared field by field. busy_limit
// is swept between phases, its extremes included.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_unit_tb;
    import acss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 190;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 30;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_CLUMPED
    } t_rx_style;

    // One directed step: the response is typed in where fixed is set.
    typedef struct {
        t_mode      md;
        logic [7:0] ch;
        logic [7:0] cnt;
        bit         fixed;
        t_rsp       rsp;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_req_valid = 1'b0;
    logic [2:0] i_mode      = '0;
    logic [7:0] i_channel   = '0;
    logic [7:0] i_count     = '0;
    logic       i_rsp_ready = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    logic       o_req_ready;
    logic       o_rsp_valid;
    logic [1:0] o_status;
    logic       o_start_valid;
    logic [4:0] o_start_channel;
    logic [7:0] o_start_count;
    logic       o_stop_request;
    logic       o_prio_go;
    logic       o_data_ready;
    logic [1:0] o_cycle_mode;
    logic       o_prio_active;

    // Shadow copy of the sequencer state.
    logic       tbl_registered [NUM_CHANNELS];
    logic [7:0] tbl_samples    [NUM_CHANNELS];
    t_chan_st   tbl_state      [NUM_CHANNELS];
    logic [7:0] tbl_stuck      [NUM_CHANNELS];
    logic [4:0] scan_pos;
    t_cycle     cycle_now;
    t_cycle     cycle_saved;
    logic       prio_held;
    logic [7:0] busy_limit;

    t_rsp       rsp_due [$];
    t_dir_row   dir_rows [$];

    int         n_errors    = 0;
    int         n_reports   = 0;
    int         n_checked   = 0;
    int         n_starts    = 0;
    int         n_released  = 0;
    int         n_settings  = 0;
    int         n_requests  = 0;
    int         mode_seen [8];
    int         burst_left  = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    int         stall_phase = 0;
    t_rx_style  stall_style = RX_OPEN;

    adc_channel_scan_sequencer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_mode          (i_mode),
        .i_channel       (i_channel),
        .i_count         (i_count),
        .o_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .o_status        (o_status),
        .o_start_valid   (o_start_valid),
        .o_start_channel (o_start_channel),
        .o_start_count   (o_start_count),
        .o_stop_request  (o_stop_request),
        .o_prio_go       (o_prio_go),
        .o_data_ready    (o_data_ready),
        .o_cycle_mode    (o_cycle_mode),
        .o_prio_active   (o_prio_active),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Walks upward from the scan position to the first registered channel
    // that is not busy; busy channels passed on the way age towards release.
    function automatic void scan_channels(inout t_rsp r);
        int         idx;
        bit         found;
        logic [7:0] n;
        idx   = int'(scan_pos);
        found = 1'b0;
        while (idx < NUM_CHANNELS && !found) begin
            if (tbl_registered[idx]) begin
                if (tbl_state[idx] != CS_BUSY) begin
                    n = (tbl_samples[idx] > DMA_BLOCK_MAX) ? 8'(DMA_BLOCK_MAX)
                                                           : tbl_samples[idx];
                    r.go_valid     = 1'b1;
                    r.go_channel   = 5'(idx);
                    r.go_count     = n;
                    tbl_state[idx] = CS_BUSY;
                    cycle_now      = CY_WORK;
                    found          = 1'b1;
                    n_starts++;
                end else begin
                    tbl_stuck[idx] = tbl_stuck[idx] + 8'd1;
                    if (tbl_stuck[idx] >= busy_limit) begin
                        tbl_stuck[idx] = '0;
                        tbl_state[idx] = CS_IDLE;
                        n_released++;
                    end
                end
            end
            if (!found) idx++;
        end
        if (!found) begin
            idx       = 0;
            cycle_now = CY_IDLE;
        end
        scan_pos = 5'(idx);
    endfunction

    function automatic t_rsp apply_event(t_mode md, logic [7:0] ch, logic [7:0] cnt);
        t_rsp r;
        int   p;
        r             = '0;
        r.status      = ST_OK;
        case (md)
            MD_TRIGGER: begin
                if (cycle_now == CY_IDLE && !prio_held) scan_channels(r);
            end
            MD_CONV_DONE: begin
                if (cycle_now == CY_WORK) begin
                    p = int'(scan_pos);
                    if (p < NUM_CHANNELS) tbl_state[p] = CS_DONE;
                    p++;
                    if (p < NUM_CHANNELS) begin
                        scan_pos = 5'(p);
                        scan_channels(r);
                    end else begin
                        scan_pos  = '0;
                        cycle_now = CY_IDLE;
                    end
                end
            end
            MD_ERROR: begin
                r.stop    = (cycle_now != CY_IDLE);
                cycle_now = CY_IDLE;
                prio_held = 1'b0;
            end
            MD_REGISTER: begin
                if (ch >= NUM_CHANNELS || cnt > DATA_DEPTH) begin
                    r.status = ST_BAD_PARAM;
                end else begin
                    tbl_registered[ch] = 1'b1;
                    tbl_samples[ch]    = cnt;
                    tbl_state[ch]      = CS_IDLE;
                end
            end
            MD_UNREGISTER: begin
                if (ch >= NUM_CHANNELS) begin
                    r.status = ST_BAD_PARAM;
                end else begin
                    tbl_registered[ch] = 1'b0;
                    tbl_samples[ch]    = '0;
                    tbl_state[ch]      = CS_IDLE;
                end
            end
            MD_PRIO_START: begin
                if (ch >= NUM_CHANNELS || cnt > DATA_DEPTH) begin
                    r.status = ST_BAD_PARAM;
                end else if (prio_held) begin
                    r.status = ST_PRIO_BUSY;
                end else begin
                    r.stop      = (cycle_now == CY_WORK);
                    cycle_saved = cycle_now;
                    cycle_now   = CY_SUSPEND;
                    prio_held   = 1'b1;
                    r.pgo       = 1'b1;
                end
            end
            MD_PRIO_END: begin
                if (prio_held) begin
                    if (cycle_saved == CY_WORK) begin
                        cycle_now = CY_WORK;
                        scan_channels(r);
                    end else begin
                        cycle_now = CY_IDLE;
                    end
                    prio_held = 1'b0;
                end
            end
            MD_QUERY: begin
                if (ch >= NUM_CHANNELS) r.status = ST_BAD_PARAM;
                else if (cnt > tbl_samples[ch]) r.status = ST_BAD_PARAM;
                else r.data_ready = (tbl_state[ch] == CS_DONE);
            end
        endcase
        r.cycle_mode  = cycle_now;
        r.prio_active = prio_held;
        return r;
    endfunction

    function automatic t_dir_row pred_row(t_mode md, logic [7:0] ch, logic [7:0] cnt);
        t_dir_row row;
        row.md    = md;
        row.ch    = ch;
        row.cnt   = cnt;
        row.fixed = 1'b0;
        row.rsp   = '0;
        return row;
    endfunction

    // A typed-in response: everything but status, cycle and priority is zero.
    function automatic t_dir_row fixed_row(t_mode md, logic [7:0] ch, logic [7:0] cnt,
                                           t_rsp_status st, t_cycle cy, logic pa);
        t_dir_row row;
        row                 = pred_row(md, ch, cnt);
        row.fixed           = 1'b1;
        row.rsp.status      = st;
        row.rsp.cycle_mode  = cy;
        row.rsp.prio_active = pa;
        return row;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        n_errors++;
        if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t: response %0d: %s is %0h, should be %0h",
                     $time, n_checked, field, got, want);
        end
    endtask

    // Opens a random gap between bursts of back-to-back requests.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic push_request(t_dir_row row);
        t_rsp p;
        pace_sender();
        i_req_valid <= 1'b1;
        i_mode      <= row.md;
        i_channel   <= row.ch;
        i_count     <= row.cnt;
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        p = apply_event(row.md, row.ch, row.cnt);
        rsp_due.push_back(row.fixed ? row.rsp : p);
        mode_seen[row.md]++;
        n_requests++;
    endtask

    task automatic drain_results();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (rsp_due.size() != 0);
    endtask

    task automatic write_busy_limit(logic [7:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        busy_limit = v;
        n_settings++;
    endtask

    // Receiver: each window picks its own stall pattern.
    always @(posedge i_clk) begin : rx_pattern
        if (stall_left == 0) begin
            stall_style = t_rx_style'($urandom_range(0, 3));
            stall_left  = $urandom_range(16, 160);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            RX_OPEN:        i_rsp_ready <= 1'b1;
            RX_COIN:        i_rsp_ready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: i_rsp_ready <= (stall_phase % 4 == 0);
            RX_CLUMPED:     i_rsp_ready <= (stall_phase % 11 > 5);
        endcase
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp got;
        t_rsp want;
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_ready) begin
            got.status      = t_rsp_status'(o_status);
            got.go_valid    = o_start_valid;
            got.go_channel  = o_start_channel;
            got.go_count    = o_start_count;
            got.stop        = o_stop_request;
            got.pgo         = o_prio_go;
            got.data_ready  = o_data_ready;
            got.cycle_mode  = t_cycle'(o_cycle_mode);
            got.prio_active = o_prio_active;
            if (rsp_due.size() == 0) begin
                report_mismatch("response with no request outstanding", 1, 0);
            end else begin
                want = rsp_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.go_valid !== want.go_valid)
                    report_mismatch("start_valid", got.go_valid, want.go_valid);
                if (got.go_channel !== want.go_channel)
                    report_mismatch("start_channel", got.go_channel, want.go_channel);
                if (got.go_count !== want.go_count)
                    report_mismatch("start_count", got.go_count, want.go_count);
                if (got.stop !== want.stop)
                    report_mismatch("stop_request", got.stop, want.stop);
                if (got.pgo !== want.pgo)
                    report_mismatch("prio_go", got.pgo, want.pgo);
                if (got.data_ready !== want.data_ready)
                    report_mismatch("data_ready", got.data_ready, want.data_ready);
                if (got.cycle_mode !== want.cycle_mode)
                    report_mismatch("cycle_mode", got.cycle_mode, want.cycle_mode);
                if (got.prio_active !== want.prio_active)
                    report_mismatch("prio_active", got.prio_active, want.prio_active);
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_req_valid && o_req_ready === 1'b1) || (o_rsp_valid === 1'b1 && i_rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("No handshake on either channel for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] phase_limits [NUM_PHASES];
        t_mode      md;
        logic [7:0] ch;
        logic [7:0] cnt;
        int         sel;
        int         done_items;

        for (int i = 0; i < NUM_CHANNELS; i++) begin
            tbl_registered[i] = 1'b0;
            tbl_samples[i]    = '0;
            tbl_state[i]      = CS_IDLE;
            tbl_stuck[i]      = '0;
        end
        for (int i = 0; i < 8; i++) mode_seen[i] = 0;
        scan_pos    = '0;
        cycle_now   = CY_IDLE;
        cycle_saved = CY_IDLE;
        prio_held   = 1'b0;
        busy_limit  = BUSY_LIMIT_RESET;

        // Directed steps, run under the reset value of busy_limit.
        dir_rows.push_back(fixed_row(MD_QUERY,      8'd0,   8'd0,   ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_TRIGGER,    8'd0,   8'd0,   ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_CONV_DONE,  8'd0,   8'd0,   ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_PRIO_END,   8'd0,   8'd0,   ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd255, 8'd0,   ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd0,   8'd255, ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd0,   8'd33,  ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_UNREGISTER, 8'd16,  8'd0,   ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_QUERY,      8'd16,  8'd0,   ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_PRIO_START, 8'd200, 8'd0,   ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd0,   8'd32,  ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd15,  8'd0,   ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_REGISTER,   8'd5,   8'd20,  ST_OK,        CY_IDLE, 1'b0));
        dir_rows.push_back(fixed_row(MD_QUERY,      8'd5,   8'd21,  ST_BAD_PARAM, CY_IDLE, 1'b0));
        dir_rows.push_back(pred_row(MD_TRIGGER,     8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_CONV_DONE,   8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_QUERY,       8'd0,   8'd32));
        dir_rows.push_back(pred_row(MD_PRIO_START,  8'd3,   8'd32));
        dir_rows.push_back(fixed_row(MD_PRIO_START, 8'd3,   8'd1,   ST_PRIO_BUSY, CY_SUSPEND, 1'b1));
        dir_rows.push_back(pred_row(MD_PRIO_END,    8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_CONV_DONE,   8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_TRIGGER,     8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_ERROR,       8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_UNREGISTER,  8'd0,   8'd0));
        dir_rows.push_back(pred_row(MD_TRIGGER,     8'd0,   8'd0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) push_request(dir_rows[i]);

        phase_limits = '{8'd1, 8'd0, 8'd255, 8'd2, BUSY_LIMIT_RESET,
                         8'($urandom_range(1, 255)), 8'd4, 8'($urandom_range(0, 255))};

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_busy_limit(phase_limits[ph]);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                // Weighted towards scan traffic with enough registrations and
                // priority requests to keep channels busy and suspended.
                sel = $urandom_range(0, 99);
                if (sel < 20)      md = MD_TRIGGER;
                else if (sel < 40) md = MD_CONV_DONE;
                else if (sel < 44) md = MD_ERROR;
                else if (sel < 60) md = MD_REGISTER;
                else if (sel < 65) md = MD_UNREGISTER;
                else if (sel < 75) md = MD_PRIO_START;
                else if (sel < 85) md = MD_PRIO_END;
                else               md = MD_QUERY;
                ch  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, NUM_CHANNELS - 1));
                cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, DATA_DEPTH + 2));
                push_request(pred_row(md, ch, cnt));
                done_items++;
                // Now and then hold the sender until every response is back.
                if ($urandom_range(0, 149) == 0) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $write("Sent %0d requests (trigger %0d, done %0d, error %0d, register %0d, ",
               n_requests, mode_seen[MD_TRIGGER], mode_seen[MD_CONV_DONE],
               mode_seen[MD_ERROR], mode_seen[MD_REGISTER]);
        $display("unregister %0d, prio start %0d, prio end %0d, query %0d) over %0d limits",
                 mode_seen[MD_UNREGISTER], mode_seen[MD_PRIO_START],
                 mode_seen[MD_PRIO_END], mode_seen[MD_QUERY], n_settings);
        $display("Checked %0d responses: %0d scan starts, %0d forced releases, %0d mismatches",
                 n_checked, n_starts, n_released, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== adc_channel_scan_sequencer_unit.f =====
hdl/acss_pkg.sv
hdl/acss_alu.sv
hdl/acss_chan_tab.sv
hdl/acss_seq.sv
hdl/adc_channel_scan_sequencer_unit.sv
sim/adc_channel_scan_sequencer_unit_tb.sv
